### rtl/core/scs_pkg.sv
// Shared types, codes and constants of the sparse column statistics block.
`default_nettype none
package scs_pkg;

  localparam int unsigned DEFAULT_MAX_COLUMNS = 1024;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN      = 32'h8000_0000;
  localparam logic [63:0] SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [62:0] SQ_MAX     = {63{1'b1}};
  localparam logic [31:0] NZ_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] ROWS_RESET = 32'd1;
  localparam logic [10:0] COLS_RESET = 11'd1024;

  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_index_e;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_READ, S_PREP, S_DIV_MEAN, S_MEAN, S_SQ, S_WRITE,
    S_MM, S_SH_LO, S_SH_HI, S_CENT, S_DIV_RAW, S_RAW, S_DIV_VAR, S_VAR,
    S_SQRT, S_SD, S_DIV_VARI, S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic [63:0] sum;
    logic [62:0] sum_sq;
    logic [31:0] nz;
    logic [62:0] cent;
  } row_t;

  localparam row_t CLEAR_ROW = '{min_v: Q_MAX, max_v: Q_MIN, sum: 64'd0,
                                 sum_sq: 63'd0, nz: 32'd0, cent: 63'd0};

  // Saturating add of two 63-bit sums.
  function automatic logic [62:0] sq_add(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? SQ_MAX : s[62:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/sparse_column_statistics.sv
// Top level of the sparse column statistics block: column store and sequencer.
`default_nettype none
// Usage:
//   Command channel: drive kind_i, column_i and value_i with start high; the
//   item is taken at a clock edge where start is high and busy is low. Kind 0
//   and 1 stream first- and second-pass nonzeros, kind 2 reads a column's
//   statistics, kind 3 clears a column. Items naming a column at or above
//   the column count (or MAX_COLUMNS) are taken and dropped at once.
//   Configuration: a write beat on cfg_valid_i/cfg_ready_o sets the row count
//   (index 0) or the column count (index 1); ready is always high.
//   Results: one beat per read, shown for exactly one cycle with done_o high.
//   The receiver cannot stall; every field is registered.
// Sequencing from accept to idle:
//   first-pass nonzero: the 32x32 multiplier and one read-modify-write of
//   the column memory; clear: one write of a cleared row.
//   second-pass nonzero and read: the shared 64-step restoring divider
//   (mean; for reads also raw moment, variance, variation) and, for reads,
//   the 32-step square root; the block is busy meanwhile.
// Reset: a sweep of all MAX_COLUMNS entries writes cleared rows into the column
//   memory; busy stays high during it, configuration writes are still taken.
module sparse_column_statistics #(
  parameter int unsigned MAX_COLUMNS = scs_pkg::DEFAULT_MAX_COLUMNS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind_i,
  input  wire logic [9:0]         column_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output logic                    done_o,
  output logic signed [31:0]      min_value_o,
  output logic signed [31:0]      max_value_o,
  output logic signed [63:0]      total_o,
  output logic [62:0]             sum_squares_o,
  output logic signed [31:0]      mean_o,
  output logic [62:0]             centered_squares_o,
  output logic [62:0]             raw_moment_o,
  output logic [62:0]             variance_o,
  output logic [31:0]             std_dev_o,
  output logic signed [31:0]      variation_o,
  output logic [1:0]              undefined_flags_o
);

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [AW-1:0] LAST_COL = AW'(MAX_COLUMNS - 1);
  localparam logic [5:0] DIV_LAST  = 6'(scs_pkg::DIV_STEPS - 1);
  localparam logic [5:0] SQRT_LAST = 6'(scs_pkg::SQRT_STEPS - 1);

  scs_pkg::state_e state_q, state_d;
  scs_pkg::kind_e  kind_q;
  logic [AW-1:0]   addr_q, sweep_q;
  logic [31:0]     value_q;
  logic [31:0]     rows_q;
  logic [10:0]     cols_q;

  scs_pkg::row_t   mem [MAX_COLUMNS];
  scs_pkg::row_t   rd_q, wr_row;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;

  // shared divider
  logic [63:0] quo_q;
  logic [31:0] rem_q, div_d_q;
  logic [5:0]  cnt_q;
  logic [32:0] div_t;
  logic        div_ge;

  // square root
  logic [63:0] rad_q;
  logic [34:0] srem_q;
  logic [31:0] root_q;
  logic [34:0] srem_t, strial;

  // multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [47:0] sq_q;
  logic [63:0] prod_q;
  logic [63:0] prodh_q;
  logic signed [31:0] mean_q;
  logic [62:0] cent_q, raw_q, var_q;
  logic [31:0] sd_q;

  logic        accept, col_ok, divisor_small;
  logic [63:0] sum_mag;
  logic [31:0] mean_mag, missing, mean_sat, vari_sat, sd_next;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic [64:0] sum_ext;
  logic [79:0] share_full;
  logic [62:0] share, var_next;
  logic [31:0] mn, mx;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign col_ok      = ({22'd0, column_i} < {21'd0, cols_q})
                    && ({22'd0, column_i} < 32'(MAX_COLUMNS));
  assign divisor_small = rows_q < 32'd2;

  // ---------------- datapath helpers ----------------
  assign sum_mag  = rd_q.sum[63] ? (64'd0 - rd_q.sum) : rd_q.sum;
  assign mean_mag = mean_q[31] ? (32'd0 - mean_q) : mean_q;
  assign missing  = (rows_q > rd_q.nz) ? (rows_q - rd_q.nz) : 32'd0;
  assign diff     = {value_q[31], value_q} - {mean_q[31], mean_q};
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign sum_ext  = {rd_q.sum[63], rd_q.sum} + {{33{value_q[31]}}, value_q};

  assign div_t  = {rem_q, quo_q[63]};
  assign div_ge = div_t >= {1'b0, div_d_q};

  assign srem_t = {srem_q[32:0], rad_q[63:62]};
  assign strial = {1'b0, root_q, 2'b01};

  assign share_full = {16'd0, prod_q} + {prodh_q[47:0], 32'd0};
  assign share      = (share_full[79:63] != 17'd0) ? scs_pkg::SQ_MAX : share_full[62:0];

  assign var_next = divisor_small ? 63'd0 : quo_q[62:0];
  assign sd_next  = (var_q[62:48] != 15'd0) ? 32'hFFFF_FFFF : root_q;

  always_comb begin
    if (rows_q == 32'd0) begin
      mean_sat = 32'd0;
    end else if (rd_q.sum[63]) begin
      mean_sat = (quo_q >= 64'h8000_0000) ? scs_pkg::Q_MIN : (32'd0 - quo_q[31:0]);
    end else begin
      mean_sat = (quo_q > 64'h7FFF_FFFF) ? scs_pkg::Q_MAX : quo_q[31:0];
    end
  end

  always_comb begin
    if (mean_q == 32'sd0) begin
      vari_sat = 32'd0;
    end else if (!mean_q[31]) begin
      vari_sat = (quo_q > 64'h7FFF_FFFF) ? scs_pkg::Q_MAX : quo_q[31:0];
    end else begin
      vari_sat = (quo_q >= 64'h8000_0000) ? scs_pkg::Q_MIN : (32'd0 - quo_q[31:0]);
    end
  end

  always_comb begin
    mn = rd_q.min_v;
    mx = rd_q.max_v;
    if (missing != 32'd0) begin
      if ($signed(mn) > 32'sd0) mn = 32'd0;
      if ($signed(mx) < 32'sd0) mx = 32'd0;
    end
  end

  // Multiplier operand select.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      scs_pkg::S_SQ: begin
        if (kind_q == scs_pkg::KIND_FIRST) begin
          mul_a = value_q[31] ? (32'd0 - value_q) : value_q;
        end else begin
          mul_a = diff_mag[31:0];
        end
        mul_b = mul_a;
      end
      scs_pkg::S_MM: begin
        mul_a = mean_mag;
        mul_b = mean_mag;
      end
      scs_pkg::S_SH_LO: begin
        mul_a = sq_q[31:0];
        mul_b = missing;
      end
      scs_pkg::S_SH_HI: begin
        mul_a = {16'd0, sq_q[47:32]};
        mul_b = missing;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scs_pkg::S_SWEEP:    if (sweep_q == LAST_COL) state_d = scs_pkg::S_IDLE;
      scs_pkg::S_IDLE: begin
        if (accept && col_ok) begin
          state_d = (scs_pkg::kind_e'(kind_i) == scs_pkg::KIND_CLEAR) ? scs_pkg::S_WRITE
                                                                      : scs_pkg::S_READ;
        end
      end
      scs_pkg::S_READ: begin
        state_d = (kind_q == scs_pkg::KIND_FIRST) ? scs_pkg::S_SQ : scs_pkg::S_PREP;
      end
      scs_pkg::S_PREP:     state_d = scs_pkg::S_DIV_MEAN;
      scs_pkg::S_DIV_MEAN: if (cnt_q == DIV_LAST) state_d = scs_pkg::S_MEAN;
      scs_pkg::S_MEAN: begin
        state_d = (kind_q == scs_pkg::KIND_SECOND) ? scs_pkg::S_SQ : scs_pkg::S_MM;
      end
      scs_pkg::S_SQ:       state_d = scs_pkg::S_WRITE;
      scs_pkg::S_WRITE:    state_d = scs_pkg::S_IDLE;
      scs_pkg::S_MM:       state_d = scs_pkg::S_SH_LO;
      scs_pkg::S_SH_LO:    state_d = scs_pkg::S_SH_HI;
      scs_pkg::S_SH_HI:    state_d = scs_pkg::S_CENT;
      scs_pkg::S_CENT:     state_d = scs_pkg::S_DIV_RAW;
      scs_pkg::S_DIV_RAW:  if (cnt_q == DIV_LAST) state_d = scs_pkg::S_RAW;
      scs_pkg::S_RAW:      state_d = scs_pkg::S_DIV_VAR;
      scs_pkg::S_DIV_VAR:  if (cnt_q == DIV_LAST) state_d = scs_pkg::S_VAR;
      scs_pkg::S_VAR:      state_d = scs_pkg::S_SQRT;
      scs_pkg::S_SQRT:     if (cnt_q == SQRT_LAST) state_d = scs_pkg::S_SD;
      scs_pkg::S_SD:       state_d = scs_pkg::S_DIV_VARI;
      scs_pkg::S_DIV_VARI: if (cnt_q == DIV_LAST) state_d = scs_pkg::S_OUT;
      scs_pkg::S_OUT:      state_d = scs_pkg::S_IDLE;
      default:             state_d = scs_pkg::S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    busy    = (state_q != scs_pkg::S_IDLE);
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_row  = scs_pkg::CLEAR_ROW;
    unique case (state_q)
      scs_pkg::S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
      end
      scs_pkg::S_WRITE: begin
        wr_en  = 1'b1;
        wr_row = rd_q;
        unique case (kind_q)
          scs_pkg::KIND_FIRST: begin
            if ($signed(value_q) < $signed(rd_q.min_v)) wr_row.min_v = value_q;
            if ($signed(value_q) > $signed(rd_q.max_v)) wr_row.max_v = value_q;
            if (sum_ext[64] != sum_ext[63]) begin
              wr_row.sum = sum_ext[64] ? scs_pkg::SUM_MIN : scs_pkg::SUM_MAX;
            end else begin
              wr_row.sum = sum_ext[63:0];
            end
            wr_row.sum_sq = scs_pkg::sq_add(rd_q.sum_sq, {15'd0, sq_q});
            if (rd_q.nz != scs_pkg::NZ_MAX) wr_row.nz = rd_q.nz + 32'd1;
          end
          scs_pkg::KIND_SECOND: begin
            wr_row.cent = scs_pkg::sq_add(rd_q.cent, {15'd0, sq_q});
          end
          default: begin
            wr_row = scs_pkg::CLEAR_ROW;
          end
        endcase
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // ---------------- column memory ----------------
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (state_q == scs_pkg::S_READ) rd_q <= mem[addr_q];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scs_pkg::S_SWEEP;
      sweep_q <= '0;
      cnt_q   <= 6'd0;
      done_o  <= 1'b0;
      rows_q  <= scs_pkg::ROWS_RESET;
      cols_q  <= scs_pkg::COLS_RESET;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == scs_pkg::S_OUT);
      if (state_q == scs_pkg::S_SWEEP) sweep_q <= sweep_q + AW'(1);
      if (state_q == scs_pkg::S_DIV_MEAN || state_q == scs_pkg::S_DIV_RAW
          || state_q == scs_pkg::S_DIV_VAR || state_q == scs_pkg::S_DIV_VARI
          || state_q == scs_pkg::S_SQRT) begin
        cnt_q <= cnt_q + 6'd1;
      end else begin
        cnt_q <= 6'd0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (scs_pkg::cfg_index_e'(cfg_index_i))
          scs_pkg::CFG_ROWS: rows_q <= cfg_data_i;
          scs_pkg::CFG_COLS: cols_q <= cfg_data_i[10:0];
          default:           rows_q <= rows_q;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= scs_pkg::kind_e'(kind_i);
      addr_q  <= AW'(column_i);
      value_q <= value_i;
    end
    unique case (state_q)
      scs_pkg::S_PREP: begin
        quo_q   <= sum_mag;
        rem_q   <= 32'd0;
        div_d_q <= rows_q;
      end
      scs_pkg::S_CENT: begin
        cent_q  <= (missing != 32'd0) ? scs_pkg::sq_add(rd_q.cent, share) : rd_q.cent;
        quo_q   <= {1'b0, rd_q.sum_sq};
        rem_q   <= 32'd0;
        div_d_q <= rows_q;
      end
      scs_pkg::S_RAW: begin
        raw_q   <= (rows_q == 32'd0) ? 63'd0 : quo_q[62:0];
        quo_q   <= {1'b0, cent_q};
        rem_q   <= 32'd0;
        div_d_q <= rows_q - 32'd1;
      end
      scs_pkg::S_VAR: begin
        var_q  <= var_next;
        rad_q  <= {var_next[47:0], 16'd0};
        srem_q <= 35'd0;
        root_q <= 32'd0;
      end
      scs_pkg::S_SD: begin
        sd_q    <= sd_next;
        quo_q   <= {16'd0, sd_next, 16'd0};
        rem_q   <= 32'd0;
        div_d_q <= mean_mag;
      end
      scs_pkg::S_DIV_MEAN, scs_pkg::S_DIV_RAW, scs_pkg::S_DIV_VAR,
      scs_pkg::S_DIV_VARI: begin
        // one restoring step: shift in a dividend bit, subtract when it fits
        if (div_ge) begin
          rem_q <= 32'(div_t - {1'b0, div_d_q});
        end else begin
          rem_q <= div_t[31:0];
        end
        quo_q <= {quo_q[62:0], div_ge};
      end
      scs_pkg::S_SQRT: begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (srem_t >= strial) begin
          srem_q <= srem_t - strial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= srem_t;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      scs_pkg::S_MEAN:  mean_q  <= mean_sat;
      scs_pkg::S_SQ:    sq_q    <= mul_p[63:16];
      scs_pkg::S_MM:    sq_q    <= mul_p[63:16];
      scs_pkg::S_SH_LO: prod_q  <= mul_p;
      scs_pkg::S_SH_HI: prodh_q <= mul_p;
      scs_pkg::S_OUT: begin
        min_value_o        <= mn;
        max_value_o        <= mx;
        total_o            <= rd_q.sum;
        sum_squares_o      <= rd_q.sum_sq;
        mean_o             <= mean_q;
        centered_squares_o <= cent_q;
        raw_moment_o       <= raw_q;
        variance_o         <= var_q;
        std_dev_o          <= sd_q;
        variation_o        <= vari_sat;
        undefined_flags_o  <= {mean_q == 32'sd0, divisor_small};
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

endmodule
`default_nettype wire
